[rtl/tnv_pkg.sv]
package tnv_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int MAX_NAME  = 9;
    localparam int NAME_W    = 5 * MAX_NAME;
    localparam int LEN_W     = 4;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int MIDX_W    = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [MIDX_W-1:0] CDATA_LEN = MIDX_W'(8);
    localparam logic [MIDX_W-1:0] CLOSE_LEN = MIDX_W'(2);

    typedef enum logic [2:0] {
        MODE_TEXT   = 3'd0,
        MODE_LT     = 3'd1,
        MODE_START  = 3'd2,
        MODE_END    = 3'd3,
        MODE_CDOPEN = 3'd4,
        MODE_CDBODY = 3'd5
    } mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

    // "![CDATA[" opener, one character per index
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h21;
            3'd1:    c = 8'h5B;
            3'd2:    c = 8'h43;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h41;
            3'd5:    c = 8'h54;
            3'd6:    c = 8'h41;
            3'd7:    c = 8'h5B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_A) && (c <= CH_Z);
    endfunction

endpackage

[rtl/markup_tag_nesting_validator.sv]
// Markup nesting checker: takes one byte of text per cycle on the s_ side, with
// s_tlast on the final byte, and returns one result per text on the m_ side,
// m_tdata[0] = 1 when the text was one well-formed root element (upper-case
// names of 1 to MAX_NAME letters, matched end tags, CDATA sections skipped,
// nesting no deeper than MAX_DEPTH). A byte is taken every cycle that s_tready
// is high; the result is registered and appears the cycle after the last byte.
// The tag stack is a row of MAX_DEPTH cells that shift down on a push and up on
// a pop, so the top entry always sits in the first cell. s_tready drops only
// while a result is held and m_tready is low.
module markup_tag_nesting_validator
    import tnv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    mode_t             mode_reg,        mode_next;
    logic              failed_reg,      failed_next;
    logic              root_closed_reg, root_closed_next;
    logic [NAME_W-1:0] name_buf_reg,    name_buf_next;
    logic [LEN_W-1:0]  name_len_reg,    name_len_next;
    logic              mismatch_reg,    mismatch_next;
    logic [MIDX_W-1:0] match_idx_reg,   match_idx_next;
    logic [DEPTH_W-1:0] depth_reg,      depth_next;
    logic              out_valid_reg,   out_valid_next;
    logic              out_res_reg,     out_res_next;

    logic     accept;
    logic     consume_en;
    logic     depth_zero;
    logic     depth_full;
    logic [4:0] letter;
    logic [4:0] top_slot;
    logic     end_ok;
    logic     result;
    stk_cmd_t cmd;
    entry_t   push_entry;
    entry_t   top;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign consume_en = accept && !failed_reg;
    assign depth_zero = (depth_reg == '0);
    assign depth_full = (depth_reg >= DEPTH_W'(MAX_DEPTH));
    assign letter     = 5'(s_tdata - CH_A);

    assign push_entry.name = name_buf_reg;
    assign push_entry.len  = name_len_reg;

    tnv_stack u_stack (
        .clk        (clk),
        .cmd        (cmd),
        .push_entry (push_entry),
        .top        (top)
    );

    always_comb
    begin
        top_slot = '0;
        for (int i = 0; i < MAX_NAME; i++)
        begin
            if (name_len_reg == LEN_W'(i))
                top_slot = top.name[5*i +: 5];
        end
    end

    assign end_ok = !mismatch_reg && (name_len_reg == top.len) && !depth_zero &&
                    (depth_reg <= DEPTH_W'(MAX_DEPTH));

    // stack commands
    always_comb
    begin
        cmd = '0;
        if (consume_en && s_tdata == CH_GT)
        begin
            case (mode_reg)
                MODE_START: cmd.push = !depth_full;
                MODE_END:   cmd.pop  = end_ok;
                default:    cmd      = '0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        mode_next        = mode_reg;
        failed_next      = failed_reg;
        root_closed_next = root_closed_reg;
        name_buf_next    = name_buf_reg;
        name_len_next    = name_len_reg;
        mismatch_next    = mismatch_reg;
        match_idx_next   = match_idx_reg;
        depth_next       = depth_reg;

        if (consume_en)
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (depth_zero)
                    begin
                        if (root_closed_reg || s_tdata != CH_LT)
                            failed_next = 1'b1;
                        else
                            mode_next = MODE_LT;
                    end
                    else if (s_tdata == CH_LT)
                        mode_next = MODE_LT;
                end
                MODE_LT:
                begin
                    if (s_tdata == CH_SLASH)
                    begin
                        if (depth_zero)
                            failed_next = 1'b1;
                        else
                        begin
                            name_len_next = '0;
                            mismatch_next = 1'b0;
                            mode_next     = MODE_END;
                        end
                    end
                    else if (s_tdata == CH_BANG)
                    begin
                        if (depth_zero)
                            failed_next = 1'b1;
                        else
                        begin
                            match_idx_next = MIDX_W'(1);
                            mode_next      = MODE_CDOPEN;
                        end
                    end
                    else if (is_upper(s_tdata))
                    begin
                        name_buf_next      = '0;
                        name_buf_next[4:0] = letter;
                        name_len_next      = LEN_W'(1);
                        mode_next          = MODE_START;
                    end
                    else
                        failed_next = 1'b1;
                end
                MODE_START:
                begin
                    if (s_tdata == CH_GT)
                    begin
                        if (depth_full)
                            failed_next = 1'b1;
                        else
                        begin
                            depth_next = depth_reg + DEPTH_W'(1);
                            mode_next  = MODE_TEXT;
                        end
                    end
                    else if (is_upper(s_tdata) && name_len_reg < LEN_W'(MAX_NAME))
                    begin
                        for (int i = 0; i < MAX_NAME; i++)
                        begin
                            if (name_len_reg == LEN_W'(i))
                                name_buf_next[5*i +: 5] = letter;
                        end
                        name_len_next = name_len_reg + LEN_W'(1);
                    end
                    else
                        failed_next = 1'b1;
                end
                MODE_END:
                begin
                    if (depth_zero || depth_reg > DEPTH_W'(MAX_DEPTH))
                        failed_next = 1'b1;
                    else if (s_tdata == CH_GT)
                    begin
                        if (end_ok)
                        begin
                            depth_next = depth_reg - DEPTH_W'(1);
                            if (depth_reg == DEPTH_W'(1))
                                root_closed_next = 1'b1;
                            mode_next = MODE_TEXT;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    else
                    begin
                        if (name_len_reg >= top.len ||
                            name_len_reg >= LEN_W'(MAX_NAME) ||
                            !is_upper(s_tdata) || top_slot != letter)
                            mismatch_next = 1'b1;
                        if (name_len_reg != '1)
                            name_len_next = name_len_reg + LEN_W'(1);
                    end
                end
                MODE_CDOPEN:
                begin
                    if (s_tdata == cdata_char(match_idx_reg[2:0]))
                    begin
                        if (match_idx_reg + MIDX_W'(1) >= CDATA_LEN)
                        begin
                            match_idx_next = '0;
                            mode_next      = MODE_CDBODY;
                        end
                        else
                            match_idx_next = match_idx_reg + MIDX_W'(1);
                    end
                    else
                        failed_next = 1'b1;
                end
                MODE_CDBODY:
                begin
                    if (s_tdata == CH_RBRK)
                    begin
                        if (match_idx_reg < CLOSE_LEN)
                            match_idx_next = match_idx_reg + MIDX_W'(1);
                    end
                    else if (s_tdata == CH_GT && match_idx_reg == CLOSE_LEN)
                    begin
                        match_idx_next = '0;
                        mode_next      = MODE_TEXT;
                    end
                    else
                        match_idx_next = '0;
                end
                default: failed_next = 1'b1;
            endcase
        end

        result = !failed_next && (mode_next == MODE_TEXT) && root_closed_next &&
                 (depth_next == '0);

        if (accept && s_tlast)
        begin
            mode_next        = MODE_TEXT;
            failed_next      = 1'b0;
            root_closed_next = 1'b0;
            name_buf_next    = '0;
            name_len_next    = '0;
            mismatch_next    = 1'b0;
            match_idx_next   = '0;
            depth_next       = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept && s_tlast)
        begin
            out_valid_next = 1'b1;
            out_res_next   = result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_TEXT;
            failed_reg      <= 1'b0;
            root_closed_reg <= 1'b0;
            name_len_reg    <= '0;
            mismatch_reg    <= 1'b0;
            match_idx_reg   <= '0;
            depth_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            failed_reg      <= failed_next;
            root_closed_reg <= root_closed_next;
            name_len_reg    <= name_len_next;
            mismatch_reg    <= mismatch_next;
            match_idx_reg   <= match_idx_next;
            depth_reg       <= depth_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_buf_reg <= name_buf_next;
        out_res_reg  <= out_res_next;
    end

endmodule

[rtl/tnv_cell.sv]
module tnv_cell
    import tnv_pkg::*;
(
    input  logic     clk,
    input  stk_cmd_t cmd,
    input  entry_t   from_above,
    input  entry_t   from_below,
    output entry_t   q
);

    entry_t d_reg;
    entry_t d_next;

    always_comb
    begin
        if (cmd.push)
            d_next = from_above;
        else if (cmd.pop)
            d_next = from_below;
        else
            d_next = d_reg;
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign q = d_reg;

endmodule

[rtl/tnv_stack.sv]
module tnv_stack
    import tnv_pkg::*;
(
    input  logic     clk,
    input  stk_cmd_t cmd,
    input  entry_t   push_entry,
    output entry_t   top
);

    entry_t q [MAX_DEPTH];

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        entry_t above;
        entry_t below;

        if (i == 0)
        begin : g_first
            assign above = push_entry;
        end
        else
        begin : g_mid
            assign above = q[i-1];
        end

        // bottom cell refills from itself on pop; never read below depth
        if (i == MAX_DEPTH - 1)
        begin : g_last
            assign below = q[i];
        end
        else
        begin : g_inner
            assign below = q[i+1];
        end

        tnv_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .q          (q[i])
        );
    end

    assign top = q[0];

endmodule
